// ===== design/length_prefixed_deframer_macros.svh =====
// Assertion macros used by the deframer frame core.
// Depends on nothing; each macro collapses to nothing under SYNTHESIS.
`ifndef LENGTH_PREFIXED_DEFRAMER_MACROS_SVH
`define LENGTH_PREFIXED_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
`define LPD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer assertion failed");
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer assertion failed");
`else
`define LPD_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LPD_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== design/lpd_pkg.sv =====
// Shared types and constants of the length-prefixed deframer.
// Depends on nothing.
`timescale 1ns / 1ps

package lpd_pkg;

    localparam int HEADER_BYTES = 6;
    localparam int BYTE_W = 8;
    localparam int LEN_W = 32;
    localparam int POS_W = 3;

    localparam logic [LEN_W-1:0] MAX_PAYLOAD_RESET = 32'd1048576;

    localparam logic [POS_W-1:0] POS_CHANNEL = 3'd0;
    localparam logic [POS_W-1:0] POS_FLAGS   = 3'd1;
    localparam logic [POS_W-1:0] POS_LEN0    = 3'd2;
    localparam logic [POS_W-1:0] POS_LEN1    = 3'd3;
    localparam logic [POS_W-1:0] POS_LEN2    = 3'd4;
    localparam logic [POS_W-1:0] POS_LEN3    = 3'd5;
    localparam logic [POS_W-1:0] POS_PAYLOAD = POS_W'(HEADER_BYTES);

    typedef enum logic [1:0] {
        ST_PAYLOAD = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_ERROR   = 2'd2
    } status_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] byte_value;
    } item_t;

endpackage

// ===== design/lpd_interfaces.sv =====
// Valid/ready channel interfaces for the byte stream and the result stream.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

interface lpd_byte_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] byte_value;

    modport source (output valid, output byte_value, input ready);
    modport sink (input valid, input byte_value, output ready);
endinterface

interface lpd_result_if;
    import lpd_pkg::*;

    logic              valid;
    logic              ready;
    status_t           status;
    logic [BYTE_W-1:0] channel;
    logic [BYTE_W-1:0] flags;
    logic [BYTE_W-1:0] data_byte;
    logic              last;

    modport source (output valid, output status, output channel, output flags,
                    output data_byte, output last, input ready);
    modport sink (input valid, input status, input channel, input flags,
                  input data_byte, input last, output ready);
endinterface

// ===== design/lpd_input_stage.sv =====
// Input register of the deframer: captures one byte per transfer.
// Depends on lpd_pkg and lpd_byte_if.
`timescale 1ns / 1ps

module lpd_input_stage (
    input  logic          clk,
    input  logic          rst_n,
    lpd_byte_if.sink      stream,
    input  logic          advance,
    output lpd_pkg::item_t item
);
    import lpd_pkg::*;

    logic              valid_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    assign stream.ready = !valid_reg || advance;
    assign take = stream.valid && stream.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= stream.byte_value;
        end
    end

    assign item.valid = valid_reg;
    assign item.byte_value = byte_reg;

endmodule

// ===== design/lpd_frame_core.sv =====
// Frame decoding state and the result register of the deframer.
// Depends on lpd_pkg, lpd_result_if and the assertion macro header.
`timescale 1ns / 1ps
`include "length_prefixed_deframer_macros.svh"

module lpd_frame_core (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lpd_pkg::LEN_W-1:0] cfg_wdata,
    input  lpd_pkg::item_t            item,
    output logic                      advance,
    lpd_result_if.source              result
);
    import lpd_pkg::*;

    logic [LEN_W-1:0]  max_payload_reg;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] chan_reg, chan_next;
    logic [BYTE_W-1:0] flags_reg, flags_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [LEN_W-1:0]  left_reg, left_next;
    logic              stuck_reg, stuck_next;

    logic              produce;
    status_t           st;
    logic [BYTE_W-1:0] dat;
    logic              lst;
    logic [POS_W-1:0]  hdr_pos;
    logic [LEN_W-1:0]  full_len;
    logic              out_free;

    logic              out_valid_reg;
    status_t           out_status_reg;
    logic [BYTE_W-1:0] out_chan_reg;
    logic [BYTE_W-1:0] out_flags_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic              out_last_reg;

    assign full_len = {item.byte_value, len_reg[LEN_W-BYTE_W-1:0]};

    always_comb
    begin
        pos_next = pos_reg;
        chan_next = chan_reg;
        flags_next = flags_reg;
        len_next = len_reg;
        left_next = left_reg;
        stuck_next = stuck_reg;
        produce = 1'b0;
        st = ST_PAYLOAD;
        dat = '0;
        lst = 1'b0;
        hdr_pos = pos_reg;

        if (stuck_reg)
        begin
            produce = 1'b1;
            st = ST_ERROR;
        end
        else if (pos_reg == POS_PAYLOAD && left_reg != '0)
        begin
            left_next = left_reg - LEN_W'(1);
            produce = 1'b1;
            dat = item.byte_value;
            if (left_reg == LEN_W'(1))
            begin
                pos_next = POS_CHANNEL;
                lst = 1'b1;
            end
        end
        else
        begin
            if (pos_reg >= POS_PAYLOAD)
            begin
                hdr_pos = POS_CHANNEL;
            end
            case (hdr_pos)
                POS_CHANNEL:
                begin
                    chan_next = item.byte_value;
                    pos_next = POS_FLAGS;
                end
                POS_FLAGS:
                begin
                    flags_next = item.byte_value;
                    len_next = '0;
                    pos_next = POS_LEN0;
                end
                POS_LEN0:
                begin
                    len_next[7:0] = item.byte_value;
                    pos_next = POS_LEN1;
                end
                POS_LEN1:
                begin
                    len_next[15:8] = item.byte_value;
                    pos_next = POS_LEN2;
                end
                POS_LEN2:
                begin
                    len_next[23:16] = item.byte_value;
                    pos_next = POS_LEN3;
                end
                default:
                begin
                    len_next = full_len;
                    if (full_len > max_payload_reg)
                    begin
                        stuck_next = 1'b1;
                        pos_next = POS_CHANNEL;
                        produce = 1'b1;
                        st = ST_ERROR;
                    end
                    else if (full_len == '0)
                    begin
                        pos_next = POS_CHANNEL;
                        produce = 1'b1;
                        st = ST_EMPTY;
                        lst = 1'b1;
                    end
                    else
                    begin
                        left_next = full_len;
                        pos_next = POS_PAYLOAD;
                    end
                end
            endcase
        end
    end

    assign out_free = !out_valid_reg || result.ready;
    assign advance = item.valid && (!produce || out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end
        else if (cfg_we)
        begin
            max_payload_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_CHANNEL;
            chan_reg <= '0;
            flags_reg <= '0;
            len_reg <= '0;
            left_reg <= '0;
            stuck_reg <= 1'b0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            chan_reg <= chan_next;
            flags_reg <= flags_next;
            len_reg <= len_next;
            left_reg <= left_next;
            stuck_reg <= stuck_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && produce)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && produce)
        begin
            out_status_reg <= st;
            out_chan_reg <= chan_next;
            out_flags_reg <= flags_next;
            out_data_reg <= dat;
            out_last_reg <= lst;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.status = out_status_reg;
    assign result.channel = out_chan_reg;
    assign result.flags = out_flags_reg;
    assign result.data_byte = out_data_reg;
    assign result.last = out_last_reg;

    `LPD_ASSERT_NEXT(a_stuck_holds, clk, rst_n, stuck_reg, stuck_reg)
    `LPD_ASSERT_SAME(a_stuck_gives_error, clk, rst_n, advance && stuck_reg,
                     produce && st == ST_ERROR)
    `LPD_ASSERT_SAME(a_left_only_in_payload, clk, rst_n, left_reg != '0,
                     pos_reg == POS_PAYLOAD)
    `LPD_ASSERT_SAME(a_last_not_error, clk, rst_n, out_valid_reg && out_last_reg,
                     out_status_reg != ST_ERROR)

endmodule

// ===== design/length_prefixed_deframer.sv =====
// A result is valid once its byte has passed the input register and then the result register.
// Throughput: one byte per cycle unless result.ready stalls; the registers decouple the sides.
// Header bytes and a payload counter decrement are each handled in one pass of logic.
// Reset (rst_n, asynchronous, active low) clears the header position and the sticky error.
// Reset also restores the maximum payload register to 1048576.
`timescale 1ns / 1ps

module length_prefixed_deframer (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [lpd_pkg::LEN_W-1:0] cfg_wdata,
    lpd_byte_if.sink                  stream,
    lpd_result_if.source              result
);
    import lpd_pkg::*;

    item_t item;
    logic  advance;

    lpd_input_stage u_input (
        .clk     (clk),
        .rst_n   (rst_n),
        .stream  (stream),
        .advance (advance),
        .item    (item)
    );

    lpd_frame_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item      (item),
        .advance   (advance),
        .result    (result)
    );

endmodule
